### rtl/core/tstf_pkg.sv
// Package: shared types and constants for the text timestamp finder.
package tstf_pkg;

  localparam int POS_WIDTH_DEF   = 32;
  localparam int GROUP_WIDTH_DEF = 16;
  localparam int OUT_POS_W       = 32;
  localparam int SEC_W           = 28;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [1:0] FORM_MS     = 2'd0;
  localparam logic [1:0] FORM_HMMSS  = 2'd1;
  localparam logic [1:0] FORM_HMM    = 2'd2;
  localparam logic [1:0] FORM_HMSS   = 2'd3;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_req_t;

  typedef struct packed {
    logic [OUT_POS_W-1:0] match_start;
    logic [OUT_POS_W-1:0] match_end;
    logic [SEC_W-1:0]     seconds;
    logic [1:0]           form;
    logic                 saturated;
  } out_req_t;

endpackage

### rtl/core/text_timestamp_finder.sv
// Top level: text timestamp finder, one character per request.
//
// Usage:
//   The input channel carries one text byte and a last flag per request
//   (in_valid / in_stall). Each request lands in an input register, and
//   once the output register can take a result, the run-tracking logic
//   updates the scan state and, when a digit/colon run closes and passes
//   the timestamp checks, loads a result request into the output register
//   (out_valid / out_stall). A character waits in the input register while
//   a held result still occupies the output register. Throughput: one
//   character per cycle while no held result stalls the input; the scan
//   state is a single register set updated in one pass. Both registers
//   advance together: while out_stall holds a finished result, the input
//   register holds its character too, and in_stall rises once a character
//   waits there.
//   cfg_we / cfg_wdata write skip_before; write it only while idle.
//   Reset (rst_n low, synchronous): empties both registers, zeroes the
//   text position, closes any open run and clears skip_before.
module text_timestamp_finder #(
  parameter int POS_WIDTH   = tstf_pkg::POS_WIDTH_DEF,
  parameter int GROUP_WIDTH = tstf_pkg::GROUP_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tstf_pkg::in_req_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tstf_pkg::out_req_t out_data,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata
);
  import tstf_pkg::*;

  localparam int PW    = POS_WIDTH;
  localparam int GW    = GROUP_WIDTH;
  localparam int WW    = GW + 4;
  localparam int CMP_W = (PW > 32) ? PW : 32;
  localparam logic [GW-1:0] GMAX = {GW{1'b1}};

  // Input register
  in_req_t  s1_req_r;
  logic     s1_vld_r, s1_vld_nxt;
  logic     s1_go;

  // Output register
  out_req_t out_req_r, out_req_nxt;
  logic     out_vld_r, out_vld_nxt;

  // Configuration
  logic [31:0] skip_r;

  // Scan state
  logic [PW-1:0] pos_r, pos_nxt;
  logic          run_r, run_nxt;
  logic [PW-1:0] start_r, start_nxt;
  logic [1:0]    ccol_r, ccol_nxt;
  logic [1:0]    pcol_r, pcol_nxt;
  logic [GW-1:0] gval_r [3];
  logic [GW-1:0] gval_nxt [3];
  logic [1:0]    glen_r [3];
  logic [1:0]    glen_nxt [3];
  logic [PW-1:0] scol_r, scol_nxt;
  logic [2:0]    clen_r, clen_nxt;
  logic          lsat_r, lsat_nxt;
  logic [PW-1:0] cend_r, cend_nxt;

  // Step logic intermediates
  logic          is_digit, is_colon, skipping;
  logic [3:0]    dval;
  logic [WW-1:0] dig_wide [3];
  logic          dig_sat [3];
  logic [2:0]    ncol;
  logic [3:0]    clen_sum;
  logic          run_mid, close;
  logic          ok;
  logic [1:0]    form;
  logic [11:0]   lead_k;
  logic [SEC_W-1:0] secs, g0_term, g1_term, g2_term;
  logic [PW-1:0] endp;

  assign s1_go    = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && out_vld_r && out_stall;

  assign is_digit = (s1_req_r.ch >= CH_ZERO) && (s1_req_r.ch <= CH_NINE);
  assign is_colon = (s1_req_r.ch == CH_COLON);
  assign dval     = s1_req_r.ch[3:0];
  assign skipping = CMP_W'(pos_r) < CMP_W'(skip_r);

  // Candidate digit append for each group: v*10 + d, clamped on overflow
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dig_wide[i] = (WW'(gval_r[i]) << 3) + (WW'(gval_r[i]) << 1) + WW'(dval);
      dig_sat[i]  = (dig_wide[i][WW-1:GW] != '0);
    end
  end

  // Advance the run state for one character
  always_comb begin
    start_nxt = start_r;
    ccol_nxt  = ccol_r;
    pcol_nxt  = pcol_r;
    scol_nxt  = scol_r;
    clen_nxt  = clen_r;
    lsat_nxt  = lsat_r;
    cend_nxt  = cend_r;
    for (int i = 0; i < 3; i++) begin
      gval_nxt[i] = gval_r[i];
      glen_nxt[i] = glen_r[i];
    end
    run_mid  = run_r;
    close    = 1'b0;
    ncol     = 3'(ccol_r) + 3'(pcol_r);
    clen_sum = 4'(clen_r) + 4'(pcol_r) + 4'd1;

    priority if (skipping) begin
      close = run_r;
    end else if (run_r && is_digit) begin
      if (pcol_r != 2'd0) begin
        if ((ccol_r < 2'd2) && (ncol >= 3'd2)) begin
          scol_nxt = pos_r - PW'(pcol_r) + PW'(ccol_r == 2'd0);
        end
        ccol_nxt = (ncol > 3'd3) ? 2'd3 : ncol[1:0];
      end
      clen_nxt = (clen_sum > 4'd7) ? 3'd7 : clen_sum[2:0];
      pcol_nxt = 2'd0;
      for (int i = 0; i < 3; i++) begin
        if (ccol_nxt == 2'(i)) begin
          gval_nxt[i] = dig_sat[i] ? GMAX : dig_wide[i][GW-1:0];
          if (glen_r[i] != 2'd3) begin
            glen_nxt[i] = glen_r[i] + 2'd1;
          end
          if ((i == 0) && dig_sat[i]) begin
            lsat_nxt = 1'b1;
          end
        end
      end
      cend_nxt = pos_r + PW'(1);
    end else if (run_r && is_colon) begin
      if (pcol_r != 2'd3) begin
        pcol_nxt = pcol_r + 2'd1;
      end
    end else if (run_r) begin
      close = 1'b1;
    end else if (is_digit) begin
      // Open a fresh run on this digit
      run_mid   = 1'b1;
      start_nxt = pos_r;
      ccol_nxt  = 2'd0;
      pcol_nxt  = 2'd0;
      scol_nxt  = '0;
      clen_nxt  = 3'd1;
      lsat_nxt  = 1'b0;
      for (int i = 0; i < 3; i++) begin
        gval_nxt[i] = '0;
        glen_nxt[i] = 2'd0;
      end
      gval_nxt[0] = GW'(dval);
      glen_nxt[0] = 2'd1;
      cend_nxt    = pos_r + PW'(1);
    end else begin
      // Outside a run, drop anything but a digit
    end

    close   = close || s1_req_r.last;
    run_nxt = run_mid && !close;
    pos_nxt = s1_req_r.last ? '0 : pos_r + PW'(1);
  end

  // Judge the clean run as it stands after this character
  always_comb begin
    ok   = 1'b0;
    form = FORM_MS;
    if (clen_nxt >= 3'd4) begin
      if (ccol_nxt == 2'd1) begin
        ok   = (glen_nxt[1] == 2'd2) && (gval_nxt[1] < GW'(60));
        form = FORM_MS;
      end else if (ccol_nxt == 2'd2) begin
        priority if ((glen_nxt[1] == 2'd2) && (glen_nxt[2] == 2'd2)) begin
          ok   = (gval_nxt[1] < GW'(60)) && (gval_nxt[2] < GW'(60));
          form = FORM_HMMSS;
        end else if ((glen_nxt[1] == 2'd2) && (glen_nxt[2] == 2'd1)) begin
          ok   = (gval_nxt[1] < GW'(60));
          form = FORM_HMM;
        end else if ((glen_nxt[1] == 2'd1) && (glen_nxt[2] == 2'd2)) begin
          ok   = (gval_nxt[2] < GW'(60));
          form = FORM_HMSS;
        end else begin
          ok = 1'b0;
        end
      end
    end

    // The HMMSS and HMSS forms scale the lead by 3600, the rest by 60
    if ((form == FORM_HMMSS) || (form == FORM_HMSS)) begin
      lead_k  = 12'd3600;
      g1_term = (SEC_W'(gval_nxt[1]) << 6) - (SEC_W'(gval_nxt[1]) << 2);
      g2_term = SEC_W'(gval_nxt[2]);
    end else begin
      lead_k  = 12'd60;
      g1_term = SEC_W'(gval_nxt[1]);
      g2_term = '0;
    end
    g0_term = SEC_W'(gval_nxt[0]) * SEC_W'(lead_k);
    secs    = g0_term + g1_term + g2_term;
    endp    = (form == FORM_HMM) ? scol_nxt : cend_nxt;

    out_req_nxt.match_start = OUT_POS_W'(start_nxt);
    out_req_nxt.match_end   = OUT_POS_W'(endp);
    out_req_nxt.seconds     = secs;
    out_req_nxt.form        = form;
    out_req_nxt.saturated   = lsat_nxt;
  end

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_valid && !in_stall) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_go) begin
      s1_vld_nxt = 1'b0;
    end

    out_vld_nxt = out_vld_r;
    if (s1_go) begin
      out_vld_nxt = run_mid && close && ok;
    end else if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      skip_r    <= '0;
      pos_r     <= '0;
      run_r     <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_we) begin
        skip_r <= cfg_wdata;
      end
      if (s1_go) begin
        pos_r <= pos_nxt;
        run_r <= run_nxt;
      end
    end
  end

  // Payload and run bookkeeping; run_r gates every use of the run fields
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_req_r <= in_data;
    end
    if (s1_go) begin
      out_req_r <= out_req_nxt;
      start_r   <= start_nxt;
      ccol_r    <= ccol_nxt;
      pcol_r    <= pcol_nxt;
      scol_r    <= scol_nxt;
      clen_r    <= clen_nxt;
      lsat_r    <= lsat_nxt;
      cend_r    <= cend_nxt;
      for (int i = 0; i < 3; i++) begin
        gval_r[i] <= gval_nxt[i];
        glen_r[i] <= glen_nxt[i];
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_req_r;

endmodule

### rtl/core/tstf_checker.sv
// Checker: port-level assertions for the text timestamp finder, with bind.
module tstf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input tstf_pkg::out_req_t out_data
);
  import tstf_pkg::*;

  // Hold a stalled result request
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result request changed or dropped");

  // Back-pressure on input only while a result is held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // A new result follows an accepted request through the input and output registers
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a matching request");

  // Come out of reset with no result
  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result present right after reset");

endmodule

bind text_timestamp_finder tstf_checker u_tstf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
